// ===== sv/cross_stencil_occlusion_filter_macros.svh =====
// assertion helpers for the filter module
`ifndef CROSS_STENCIL_OCCLUSION_FILTER_MACROS_SVH
`define CROSS_STENCIL_OCCLUSION_FILTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define CSOF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CSOF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/csof_pkg.sv =====
package csof_pkg;

	// register file contents
	typedef struct packed {
		logic [8:0] grid_width;
		logic [8:0] grid_height;
		logic [7:0] first_column;
		logic [7:0] last_column;
		logic [7:0] first_row;
		logic [7:0] last_row;
	} cfg_t;

	typedef enum logic [2:0] {
		REG_GRID_WIDTH   = 3'd0,
		REG_GRID_HEIGHT  = 3'd1,
		REG_FIRST_COLUMN = 3'd2,
		REG_LAST_COLUMN  = 3'd3,
		REG_FIRST_ROW    = 3'd4,
		REG_LAST_ROW     = 3'd5
	} reg_idx_t;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// one line store entry holds {upper row, middle row}
	localparam int LINE_DW = 16;

	localparam logic [7:0] OCC_MAX = 8'd170;

	// floor(s / 6) for s up to 1020: s * 683 / 4096 is exact in that range
	function automatic logic [7:0] div6(input logic [9:0] s);
		logic [19:0] prod;
		begin
			prod = 20'(s) * 20'd683;
			return prod[19:12];
		end
	endfunction

endpackage

// ===== sv/csof_line_mem.sv =====
module csof_line_mem #(
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [AW-1:0]                     waddr,
	input  logic [csof_pkg::LINE_DW-1:0]      wdata,
	input  logic [AW-1:0]                     raddr_a,
	input  logic [AW-1:0]                     raddr_b,
	output logic [csof_pkg::LINE_DW-1:0]      rdata_a,
	output logic [csof_pkg::LINE_DW-1:0]      rdata_b
);

	logic [csof_pkg::LINE_DW-1:0] store_q [DEPTH];
	logic [csof_pkg::LINE_DW-1:0] rdata_a_q;
	logic [csof_pkg::LINE_DW-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
	end

	// write-first on both read ports
	always_ff @(posedge clk) begin
		if (we && waddr == raddr_a) begin
			rdata_a_q <= wdata;
		end else begin
			rdata_a_q <= store_q[raddr_a];
		end
		if (we && waddr == raddr_b) begin
			rdata_b_q <= wdata;
		end else begin
			rdata_b_q <= store_q[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

// ===== sv/csof_regs.sv =====
module csof_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [csof_pkg::ADDR_W-1:0]      paddr,
	input  logic [csof_pkg::DATA_W-1:0]      pwdata,
	output logic [csof_pkg::DATA_W-1:0]      prdata,
	output logic                             pready,
	output csof_pkg::cfg_t                   cfg,
	output csof_pkg::cfg_t                   cfg_next
);

	csof_pkg::cfg_t   cfg_q;
	csof_pkg::cfg_t   cfg_d;
	csof_pkg::reg_idx_t idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = csof_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_comb begin
		cfg_d = cfg_q;
		if (wr_en) begin
			case (idx)
				csof_pkg::REG_GRID_WIDTH:   cfg_d.grid_width   = pwdata[8:0];
				csof_pkg::REG_GRID_HEIGHT:  cfg_d.grid_height  = pwdata[8:0];
				csof_pkg::REG_FIRST_COLUMN: cfg_d.first_column = pwdata[7:0];
				csof_pkg::REG_LAST_COLUMN:  cfg_d.last_column  = pwdata[7:0];
				csof_pkg::REG_FIRST_ROW:    cfg_d.first_row    = pwdata[7:0];
				csof_pkg::REG_LAST_ROW:     cfg_d.last_row     = pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width   <= 9'd256;
			cfg_q.grid_height  <= 9'd256;
			cfg_q.first_column <= 8'd1;
			cfg_q.last_column  <= 8'd254;
			cfg_q.first_row    <= 8'd1;
			cfg_q.last_row     <= 8'd254;
		end else begin
			cfg_q <= cfg_d;
		end
	end

	always_comb begin
		case (idx)
			csof_pkg::REG_GRID_WIDTH:   prdata = 32'(cfg_q.grid_width);
			csof_pkg::REG_GRID_HEIGHT:  prdata = 32'(cfg_q.grid_height);
			csof_pkg::REG_FIRST_COLUMN: prdata = 32'(cfg_q.first_column);
			csof_pkg::REG_LAST_COLUMN:  prdata = 32'(cfg_q.last_column);
			csof_pkg::REG_FIRST_ROW:    prdata = 32'(cfg_q.first_row);
			csof_pkg::REG_LAST_ROW:     prdata = 32'(cfg_q.last_row);
			default:                    prdata = '0;
		endcase
	end

	assign cfg      = cfg_q;
	assign cfg_next = cfg_d;

endmodule

// ===== sv/cross_stencil_occlusion_filter.sv =====
// Cross-stencil occlusion filter. Height samples enter in raster order, one beat per clock
// while in_stall is low, and each accepted sample at (c, r) finishes the position (c, r-1)
// above it: when that position lies in the configured rectangle a result beat with
// max(0, floor((up + down + left + right) / 6) - centre) and its column and row is loaded
// into the output register. Neighbors outside the grid count as zero, and the
// bottom row never produces results. The two previous rows live in one line store of
// MAX_WIDTH entries with one write and two registered read ports; the reads for the next
// column and its right neighbor are issued in the cycle before, so the store sets the
// one-sample-per-clock rate. There is no clearing pass after reset. Configuration written in
// mid frame takes effect at once and keeps the position counters.
`include "cross_stencil_occlusion_filter_macros.svh"

module cross_stencil_occlusion_filter #(
	parameter int MAX_WIDTH = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [csof_pkg::ADDR_W-1:0]      paddr,
	input  logic [csof_pkg::DATA_W-1:0]      pwdata,
	output logic [csof_pkg::DATA_W-1:0]      prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       height_sample,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       occlusion,
	output logic [7:0]                       out_column,
	output logic [7:0]                       out_row
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WB = (CW + 1 > 9) ? CW + 1 : 9;

	csof_pkg::cfg_t cfg;
	csof_pkg::cfg_t cfg_next;

	logic [CW-1:0]  col_q;
	logic [7:0]     row_q;
	logic [7:0]     left_q;
	logic           out_valid_q;
	logic [7:0]     occ_q;
	logic [7:0]     col_out_q;
	logic [7:0]     row_out_q;

	logic           in_acc;
	logic [WB-1:0]  w;
	logic [8:0]     h;
	logic [WB-1:0]  c_wb;
	logic [WB-1:0]  c_plus1;
	logic [CW-1:0]  c;
	logic [7:0]     r;
	logic [8:0]     r_plus1;
	logic           last_col;
	logic           last_row;
	logic [CW-1:0]  col_next;
	logic [7:0]     row_next;
	logic [CW-1:0]  cn;
	logic [CW-1:0]  raddr_b;

	logic [csof_pkg::LINE_DW-1:0] rdata_a;
	logic [csof_pkg::LINE_DW-1:0] rdata_b;

	logic [7:0]     centre;
	logic [7:0]     up;
	logic [7:0]     left_nb;
	logic [7:0]     right_nb;
	logic [9:0]     nb_sum;
	logic [7:0]     quot;
	logic [7:0]     occ_val;
	logic [7:0]     p;
	logic           emit;

	function automatic logic [WB-1:0] eff_width(input logic [8:0] gw);
		logic [WB-1:0] gw_ext;
		begin
			gw_ext = WB'(gw);
			if (gw == 9'd0) begin
				return WB'(1);
			end else if (gw_ext > WB'(MAX_WIDTH)) begin
				return WB'(MAX_WIDTH);
			end else begin
				return gw_ext;
			end
		end
	endfunction

	csof_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cfg      (cfg),
		.cfg_next (cfg_next)
	);

	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	// effective grid size and counters folded back into it
	always_comb begin
		w = eff_width(cfg.grid_width);
		if (cfg.grid_height == 9'd0) begin
			h = 9'd1;
		end else if (cfg.grid_height > 9'd256) begin
			h = 9'd256;
		end else begin
			h = cfg.grid_height;
		end
		c_wb     = (WB'(col_q) >= w) ? '0 : WB'(col_q);
		c        = c_wb[CW-1:0];
		c_plus1  = c_wb + WB'(1);
		r        = ({1'b0, row_q} >= h) ? 8'd0 : row_q;
		r_plus1  = {1'b0, r} + 9'd1;
		last_col = c_plus1 >= w;
		last_row = r_plus1 >= h;
	end

	always_comb begin
		col_next = col_q;
		row_next = row_q;
		if (in_acc) begin
			if (last_col) begin
				col_next = '0;
				row_next = last_row ? 8'd0 : r_plus1[7:0];
			end else begin
				col_next = c_plus1[CW-1:0];
				row_next = r;
			end
		end
	end

	// prefetch the column that the next beat will see, against next cycle's width
	always_comb begin
		cn      = (WB'(col_next) >= eff_width(cfg_next.grid_width)) ? '0 : col_next;
		raddr_b = cn + CW'(1);
	end

	csof_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_mem (
		.clk     (clk),
		.we      (in_acc),
		.waddr   (c),
		.wdata   ({centre, height_sample}),
		.raddr_a (cn),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_comb begin
		centre   = rdata_a[7:0];
		up       = (r >= 8'd2) ? rdata_a[15:8] : 8'd0;
		left_nb  = (c_wb != '0) ? left_q : 8'd0;
		right_nb = last_col ? 8'd0 : rdata_b[7:0];
		nb_sum   = 10'(up) + 10'(height_sample) + 10'(left_nb) + 10'(right_nb);
		quot     = csof_pkg::div6(nb_sum);
		occ_val  = (quot > centre) ? quot - centre : 8'd0;
		p        = r - 8'd1;
		emit     = (r != 8'd0) && (p >= cfg.first_row) && (p <= cfg.last_row)
			&& (c_wb >= WB'(cfg.first_column)) && (c_wb <= WB'(cfg.last_column));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= 8'd0;
			left_q      <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			col_q <= col_next;
			row_q <= row_next;
			if (in_acc) begin
				left_q      <= centre;
				out_valid_q <= emit;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			occ_q     <= occ_val;
			col_out_q <= c_wb[7:0];
			row_out_q <= p;
		end
	end

	assign out_valid  = out_valid_q;
	assign occlusion  = occ_q;
	assign out_column = col_out_q;
	assign out_row    = row_out_q;

	`CSOF_ASSERT_NXT(a_emit_beat, in_acc && emit, out_valid && occlusion == $past(occ_val), "result beat lost")
	`CSOF_ASSERT_IMP(a_occ_range, out_valid, occlusion <= csof_pkg::OCC_MAX, "occlusion out of range")
	`CSOF_ASSERT_NXT(a_col_step, in_acc && !last_col, WB'(col_q) == $past(c_plus1), "column count skipped")
	`CSOF_ASSERT_NXT(a_row_step, in_acc && last_col && !last_row, 9'(row_q) == $past(r_plus1), "row count skipped")

endmodule
